// ===== src/pli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;

  localparam int unsigned MaxPoints     = 256;
  localparam int unsigned MaxComponents = 4;
  localparam int unsigned ValueBits     = 32;
  localparam int unsigned PtrBits       = $clog2(MaxPoints);
  localparam int unsigned CompBits      = $clog2(MaxComponents);
  localparam int unsigned OrdAddrBits   = PtrBits + CompBits;

  typedef enum logic [1:0] {
    ModeWrX     = 2'd0,
    ModeWrY     = 2'd1,
    ModeQuery   = 2'd2,
    ModeRestart = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatBeyond  = 2'd1,
    StatOrder   = 2'd2,
    StatZeroDx  = 2'd3
  } status_e;

  localparam logic CfgPointCount     = 1'b0;
  localparam logic CfgComponentCount = 1'b1;

endpackage

// ===== src/pli_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module pli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/pli_div.sv =====
// Radix-2 restoring divider for the signed Q15.16 interpolation fraction.
module pli_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [pli_pkg::ValueBits:0] num_i,
  input  logic signed [pli_pkg::ValueBits:0] den_i,
  output logic                           done_o,
  output logic signed [pli_pkg::ValueBits-1:0] quot_o
);
  import pli_pkg::*;
  localparam int unsigned NumBits = ValueBits + 17;
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] n_q, n_d;
  logic [ValueBits:0] r_q, r_d, dabs_q, dabs_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [ValueBits+1:0] trial;
  logic [NumBits-1:0] nabs;
  logic [NumBits:0]   qs;
  logic signed [NumBits:0] qsig;

  always_comb begin
    nabs  = num_i[ValueBits] ? NumBits'(-{{16{num_i[ValueBits]}}, num_i, 16'd0})
                             : NumBits'({num_i, 16'd0});
    trial = {r_q, n_q[NumBits-1]} - {1'b0, dabs_q};
    n_d = n_q; r_d = r_q; dabs_d = dabs_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    if (start_i) begin
      n_d    = nabs;
      r_d    = '0;
      dabs_d = den_i[ValueBits] ? (ValueBits+1)'(-den_i) : den_i;
      neg_d  = num_i[ValueBits] ^ den_i[ValueBits];
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[ValueBits+1]) begin
        r_d = trial[ValueBits:0];
        n_d = {n_q[NumBits-2:0], 1'b1};
      end else begin
        r_d = {r_q[ValueBits-1:0], n_q[NumBits-1]};
        n_d = {n_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; dabs_q <= dabs_d; neg_q <= neg_d;
  end

  always_comb begin
    qs   = {1'b0, n_q};
    qsig = neg_q ? -$signed(qs) : $signed(qs);
    if (qsig > $signed((NumBits+1)'({1'b0, {(ValueBits-1){1'b1}}}))) begin
      quot_o = {1'b0, {(ValueBits-1){1'b1}}};
    end else if (qsig < -$signed((NumBits+1)'({1'b1, {(ValueBits-1){1'b0}}}))) begin
      quot_o = {1'b1, {(ValueBits-1){1'b0}}};
    end else begin
      quot_o = qsig[ValueBits-1:0];
    end
  end
  assign done_o = done_q;
endmodule

// ===== src/piecewise_linear_interpolator_core.sv =====
// Top level of the piecewise linear interpolator with vector ordinates.
// One item is handled at a time. A query walks the segment pointer forward
// one breakpoint at a time (one abscissa RAM read each), reads the segment
// ends, runs a bit-serial divide for the fraction, and then reads two
// ordinates and does one multiply per component.
// Results go through an output register, so the next item may be accepted
// while the last result still waits. Out of order queries and zero-width
// segments skip the divide.
module piecewise_linear_interpolator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        mode_i,
  input  logic [7:0]                        entry_index_i,
  input  logic [1:0]                        component_index_i,
  input  logic signed [31:0]                value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                result_value_o,
  output logic [1:0]                        result_component_o,
  output logic                              last_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);
  import pli_pkg::*;

  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StSeek   = 11'b00000000010,
    StSeekW  = 11'b00000000100,
    StXm     = 11'b00000001000,
    StXmW    = 11'b00000010000,
    StXl     = 11'b00000100000,
    StXlW    = 11'b00001000000,
    StDiv    = 11'b00010000000,
    StYm     = 11'b00100000000,
    StYp     = 11'b01000000000,
    StEmit   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [8:0] pcount_q;
  logic [2:0] ccount_q;
  logic [PtrBits-1:0] seg_q, seg_d;
  logic signed [31:0] prev_q, prev_d, qv_q, qv_d;
  logic started_q, started_d;
  logic signed [31:0] xm_q, xm_d, xp_q, xp_d, ym_q, ym_d;
  logic [1:0] stat_q, stat_d;
  logic [CompBits-1:0] comp_q, comp_d;
  logic order_q, order_d;
  logic signed [31:0] f_q, f_d;
  logic ov_q, ov_d;
  logic signed [31:0] rv_q, rv_d;
  logic [1:0] rc_q, rc_d, rs_q, rs_d;
  logic rl_q, rl_d;

  logic [8:0] n;
  logic [2:0] cc;
  logic [PtrBits-1:0] last_seg, last_pt;
  logic x_we, y_we;
  logic [PtrBits-1:0] x_addr;
  logic [OrdAddrBits-1:0] y_addr;
  logic signed [31:0] x_rd, y_rd;
  logic div_start, div_done;
  logic signed [32:0] div_num, div_den;
  logic signed [31:0] div_q;
  logic signed [32:0] dy;
  logic signed [64:0] prod;
  logic signed [48:0] ysum;
  logic out_free, accept;

  assign n  = (pcount_q < 9'd2) ? 9'd2 : (pcount_q > 9'(MaxPoints)) ? 9'(MaxPoints) : pcount_q;
  assign cc = (ccount_q < 3'd1) ? 3'd1 :
              (ccount_q > 3'(MaxComponents)) ? 3'(MaxComponents) : ccount_q;
  assign last_seg = PtrBits'(n - 9'd2);
  assign last_pt  = PtrBits'(n - 9'd1);

  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  pli_ram #(.Width(32), .Depth(MaxPoints)) u_xram (
    .clk_i, .we_i(x_we), .addr_i(x_addr), .wdata_i(value_i), .rdata_o(x_rd)
  );
  pli_ram #(.Width(32), .Depth(MaxPoints * MaxComponents)) u_yram (
    .clk_i, .we_i(y_we), .addr_i(y_addr), .wdata_i(value_i), .rdata_o(y_rd)
  );

  assign div_num = 33'(qv_q) - 33'(xm_q);
  assign div_den = 33'(xp_q) - 33'(xm_q);
  pli_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q)
  );

  // The multiply is registered through f_q and ym_q; the sum follows the product.
  assign dy   = 33'(y_rd) - 33'(ym_q);
  assign prod = 65'(f_q) * 65'(dy);
  assign ysum = 49'(ym_q) + 49'(prod >>> 16);

  always_comb begin
    state_d = state_q; seg_d = seg_q; prev_d = prev_q; qv_d = qv_q;
    started_d = started_q; xm_d = xm_q; xp_d = xp_q; ym_d = ym_q;
    stat_d = stat_q; comp_d = comp_q; order_d = order_q; f_d = f_q;
    ov_d = ov_q && !out_ready_i; rv_d = rv_q; rc_d = rc_q; rs_d = rs_q; rl_d = rl_q;
    x_we = 1'b0; y_we = 1'b0; div_start = 1'b0;
    x_addr = entry_index_i[PtrBits-1:0];
    y_addr = {entry_index_i[PtrBits-1:0], component_index_i[CompBits-1:0]};
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (mode_e'(mode_i))
            ModeWrX: x_we = 1'b1;
            ModeWrY: y_we = 1'b1;
            ModeRestart: begin
              seg_d = '0;
              started_d = 1'b0;
            end
            ModeQuery: begin
              qv_d = value_i;
              comp_d = '0;
              if (started_q && value_i <= prev_q) begin
                order_d = 1'b1;
                stat_d  = StatOrder;
                state_d = StEmit;
              end else begin
                order_d = 1'b0;
                started_d = 1'b1;
                prev_d = value_i;
                if (seg_q > last_seg) seg_d = last_seg;
                state_d = StSeek;
              end
            end
            default: ;
          endcase
        end
      end
      StSeek: begin
        if (seg_q < last_seg) begin
          x_addr = seg_q + 1'b1;
          state_d = StSeekW;
        end else begin
          state_d = StXm;
        end
      end
      StSeekW: begin
        if (x_rd < qv_q) begin
          seg_d = seg_q + 1'b1;
          state_d = StSeek;
        end else begin
          state_d = StXm;
        end
      end
      StXm: begin
        x_addr = seg_q;
        state_d = StXmW;
      end
      StXmW: begin
        xm_d = x_rd;
        x_addr = seg_q + 1'b1;
        state_d = StXl;
      end
      StXl: begin
        xp_d = x_rd;
        x_addr = last_pt;
        state_d = StXlW;
      end
      StXlW: begin
        if (xp_q == xm_q) stat_d = StatZeroDx;
        else if (qv_q > x_rd) stat_d = StatBeyond;
        else stat_d = StatOk;
        if (xp_q == xm_q) begin
          f_d = '0;
          state_d = StYm;
        end else begin
          div_start = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          f_d = div_q;
          state_d = StYm;
        end
      end
      StYm: begin
        y_addr = {seg_q, comp_q};
        state_d = StYp;
      end
      StYp: begin
        ym_d = y_rd;
        y_addr = {seg_q + 1'b1, comp_q};
        state_d = StEmit;
      end
      StEmit: begin
        // Keep reading the upper ordinate so it stays valid while the output stalls.
        y_addr = {seg_q + 1'b1, comp_q};
        if (out_free) begin
          ov_d = 1'b1;
          rc_d = 2'(comp_q);
          rs_d = stat_q;
          rl_d = (3'(comp_q) == cc - 3'd1);
          if (order_q) rv_d = '0;
          else if (stat_q == StatZeroDx) rv_d = ym_q;
          else if (ysum > 49'sh0_7FFF_FFFF) rv_d = 32'sh7FFF_FFFF;
          else if (ysum < -49'sh0_8000_0000) rv_d = 32'sh8000_0000;
          else rv_d = ysum[31:0];
          comp_d = comp_q + 1'b1;
          if (3'(comp_q) == cc - 3'd1) state_d = StIdle;
          else state_d = order_q ? StEmit : StYm;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pcount_q <= 9'd2;
      ccount_q <= 3'd1;
      seg_q <= '0;
      prev_q <= '0;
      started_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seg_q <= seg_d;
      prev_q <= prev_d;
      started_q <= started_d;
      ov_q <= ov_d;
      if (cfg_valid_i && cfg_index_i == CfgPointCount) pcount_q <= cfg_data_i[8:0];
      if (cfg_valid_i && cfg_index_i == CfgComponentCount) ccount_q <= cfg_data_i[2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    qv_q <= qv_d; xm_q <= xm_d; xp_q <= xp_d; ym_q <= ym_d; stat_q <= stat_d;
    comp_q <= comp_d; order_q <= order_d; f_q <= f_d;
    rv_q <= rv_d; rc_q <= rc_d; rs_q <= rs_d; rl_q <= rl_d;
  end

  assign out_valid_o        = ov_q;
  assign result_value_o     = rv_q;
  assign result_component_o = rc_q;
  assign last_o             = rl_q;
  assign status_o           = rs_q;
endmodule

// ===== src/pli_checker.sv =====
// Port-level checks for the interpolator, bound to the top level.
module pli_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_value_o,
  input logic [1:0]  result_component_o,
  input logic        last_o,
  input logic [1:0]  status_o
);
  import pli_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatOrder |-> result_value_o == '0)
    else $error("out of order result is not zero");

  // While a non-final component waits, the rest of that query is still being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input accepted in the middle of a query");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o ##1 out_valid_o && out_ready_i
    |-> result_component_o == $past(result_component_o) + 2'd1)
    else $error("component sequence broken");
endmodule

bind piecewise_linear_interpolator_core pli_checker u_pli_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .result_value_o, .result_component_o, .last_o, .status_o
);
